// File: src/nsc_pkg.sv
// nsc_pkg: shared types, character codes and helpers of the NMEA sentence checker.
// Depends on nothing; used by nsc_engine and nmea_sentence_checker.
package nsc_pkg;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_BODY,
		PH_HEX1,
		PH_HEX2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MISMATCH  = 2'd1,
		ST_MALFORMED = 2'd2
	} status_t;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	localparam int MIN_BODY = 4;
	localparam int ADDR_LEN = 5;

	// one result of a finished sentence
	typedef struct packed {
		logic       valid;
		status_t    status;
		logic       is_gga;
		logic [7:0] computed_sum;
		logic [7:0] received_sum;
		logic [7:0] body_length;
	} result_t;

	// {bad, value}: bad is set for anything that is not a hex digit of either case
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c - 8'h30;
			return {1'b0, v[3:0]};
		end
		if (c inside {[8'h41:8'h46]}) begin
			v = c - 8'h37;
			return {1'b0, v[3:0]};
		end
		if (c inside {[8'h61:8'h66]}) begin
			v = c - 8'h57;
			return {1'b0, v[3:0]};
		end
		return 5'b1_0000;
	endfunction

	// expected address character; gn selects GNGGA over GPGGA
	function automatic logic [7:0] addr_char(input logic [2:0] idx, input logic gn);
		case (idx)
			3'd0:    return 8'h47;                 // G
			3'd1:    return gn ? 8'h4E : 8'h50;    // N or P
			3'd2:    return 8'h47;                 // G
			3'd3:    return 8'h47;                 // G
			3'd4:    return 8'h41;                 // A
			default: return 8'h00;
		endcase
	endfunction

endpackage

// File: src/nsc_engine.sv
// nsc_engine: per-byte sentence state machine with checksum, hex and address tracking.
// Depends on nsc_pkg. Result is combinational from the current byte and state.
module nsc_engine #(
	parameter int MAX_SENTENCE = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output nsc_pkg::result_t    result
);

	localparam int CNT_W = $clog2(MAX_SENTENCE + 1);
	localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

	nsc_pkg::phase_t   phase_q, phase_d;
	logic [7:0]        xor_q, xor_d;
	logic [3:0]        nib_q, nib_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              gp_q, gp_d;
	logic              gn_q, gn_d;
	logic              herr_q, herr_d;

	logic              line_end;
	logic [4:0]        hex;
	logic              in_addr;
	logic [EXT_W-1:0]  cnt_ext;
	logic [7:0]        rsum;

	assign line_end = (rx_byte == nsc_pkg::CH_CR) || (rx_byte == nsc_pkg::CH_LF);
	assign hex      = nsc_pkg::hex_decode(rx_byte);
	assign in_addr  = cnt_q < CNT_W'(nsc_pkg::ADDR_LEN);
	assign cnt_ext  = EXT_W'(cnt_q);
	assign rsum     = {nib_q, hex[3:0]};

	// next state
	always_comb begin
		phase_d = phase_q;
		xor_d   = xor_q;
		nib_d   = nib_q;
		cnt_d   = cnt_q;
		gp_d    = gp_q;
		gn_d    = gn_q;
		herr_d  = herr_q;
		if (rx_byte == nsc_pkg::CH_DOLLAR) begin
			phase_d = nsc_pkg::PH_BODY;
			xor_d   = 8'd0;
			nib_d   = 4'd0;
			cnt_d   = '0;
			gp_d    = 1'b1;
			gn_d    = 1'b1;
			herr_d  = 1'b0;
		end else begin
			case (phase_q)
				nsc_pkg::PH_BODY: begin
					if (rx_byte == nsc_pkg::CH_STAR) begin
						phase_d = nsc_pkg::PH_HEX1;
					end else if (line_end) begin
						phase_d = nsc_pkg::PH_IDLE;
					end else if (cnt_q >= CNT_W'(MAX_SENTENCE)) begin
						phase_d = nsc_pkg::PH_IDLE;     // overlong: drop quietly
					end else begin
						if (in_addr) begin
							if (rx_byte != nsc_pkg::addr_char(cnt_q[2:0], 1'b0)) gp_d = 1'b0;
							if (rx_byte != nsc_pkg::addr_char(cnt_q[2:0], 1'b1)) gn_d = 1'b0;
						end
						xor_d = xor_q ^ rx_byte;
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
				nsc_pkg::PH_HEX1: begin
					if (line_end) begin
						phase_d = nsc_pkg::PH_IDLE;
					end else begin
						herr_d  = herr_q | hex[4];
						nib_d   = hex[4] ? 4'd0 : hex[3:0];
						phase_d = nsc_pkg::PH_HEX2;
					end
				end
				nsc_pkg::PH_HEX2: phase_d = nsc_pkg::PH_IDLE;
				default:          phase_d = nsc_pkg::PH_IDLE;
			endcase
		end
	end

	// result
	always_comb begin
		result              = '0;
		result.status       = nsc_pkg::ST_MALFORMED;
		result.is_gga       = !in_addr && (gp_q || gn_q);
		result.computed_sum = xor_q;
		result.body_length  = cnt_ext[7:0];
		if (rx_byte != nsc_pkg::CH_DOLLAR) begin
			case (phase_q)
				nsc_pkg::PH_BODY: result.valid = line_end;
				nsc_pkg::PH_HEX1: result.valid = line_end;
				nsc_pkg::PH_HEX2: begin
					result.valid = 1'b1;
					if (!line_end && !hex[4] && !herr_q) begin
						result.received_sum = rsum;
						if (cnt_q >= CNT_W'(nsc_pkg::MIN_BODY)) begin
							result.status = (rsum == xor_q) ? nsc_pkg::ST_OK
							                                : nsc_pkg::ST_MISMATCH;
						end
					end
				end
				default: result.valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nsc_pkg::PH_IDLE;
			xor_q   <= 8'd0;
			nib_q   <= 4'd0;
			cnt_q   <= '0;
			gp_q    <= 1'b1;
			gn_q    <= 1'b1;
			herr_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			xor_q   <= xor_d;
			nib_q   <= nib_d;
			cnt_q   <= cnt_d;
			gp_q    <= gp_d;
			gn_q    <= gn_d;
			herr_q  <= herr_d;
		end
	end

endmodule

// File: src/nmea_sentence_checker.sv
// nmea_sentence_checker: top level of the NMEA 0183 sentence checksum checker.
// Depends on nsc_pkg and nsc_engine.
//
//  channel | signals                        | dir | transaction
//  --------+--------------------------------+-----+-----------------------------------
//  input   | in_valid, in_ready, rx_byte    | in  | one received character
//  output  | out_valid, out_ready, status,  | out | one result per finished sentence
//          | is_gga, computed_sum,          |     |
//          | received_sum, body_length      |     |
//
// One character per cycle while out_ready keeps up. A byte is registered in the input
// stage, and the sentence engine (XOR, hex decode, address compare) then updates its
// state from it and, at the end of a sentence, loads the output register.
// The output register is taken by the downstream side while the next bytes flow;
// only when a result waits and a further byte would need to step the engine does
// the input stage hold, and in_ready drops once it is full.
// Reset clears the valid flags and puts the engine back to waiting for '$'.
module nmea_sentence_checker #(
	parameter int MAX_SENTENCE = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic       is_gga,
	output logic [7:0] computed_sum,
	output logic [7:0] received_sum,
	output logic [7:0] body_length
);

	// input stage
	logic             valid_s1;
	logic [7:0]       rx_s1;

	// output register
	logic             out_valid_q;
	nsc_pkg::status_t status_q;
	logic             is_gga_q;
	logic [7:0]       computed_q;
	logic [7:0]       received_q;
	logic [7:0]       length_q;

	logic             advance;
	nsc_pkg::result_t res;

	// the engine steps when the output register can take whatever this byte yields
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	nsc_engine #(
		.MAX_SENTENCE(MAX_SENTENCE)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (rx_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			status_q   <= res.status;
			is_gga_q   <= res.is_gga;
			computed_q <= res.computed_sum;
			received_q <= res.received_sum;
			length_q   <= res.body_length;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign is_gga       = is_gga_q;
	assign computed_sum = computed_q;
	assign received_sum = received_q;
	assign body_length  = length_q;

	// a result produced by the engine always lands in the output register
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid) |=> out_valid)
		else $error("engine result not registered");

	// ok means the two sums agree
	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == nsc_pkg::ST_OK) |-> (computed_sum == received_sum))
		else $error("ok status with differing sums");

	// mismatch means they differ
	a_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == nsc_pkg::ST_MISMATCH) |-> (computed_sum != received_sum))
		else $error("mismatch status with equal sums");

	// a malformed result keeps a decoded sum only for a too-short body
	a_short_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == nsc_pkg::ST_MALFORMED && received_sum != 8'd0)
		|-> (body_length < 8'd4))
		else $error("malformed result carries a sum on a full-length body");

endmodule

// File: tb/sv/tb_nmea_sentence_checker.sv
// tb_nmea_sentence_checker: self-checking testbench for the NMEA 0183 sentence checker.
// Depends on nsc_pkg (status and phase enums, character codes) and nmea_sentence_checker.
`timescale 1ns / 100ps

module tb_nmea_sentence_checker;

	localparam int MAX_BODY      = 128;
	// non-ignored characters in the random part; with the directed rows and the
	// ignored bytes the run sends about 1800 characters in all
	localparam int RANDOM_CHARS  = 1250;
	localparam int DRAIN_CYCLES  = 16;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int IDLE_PCT      = 31;
	localparam int REPORT_MAX    = 10;

	localparam logic [39:0] ADDR_GP = "GPGGA";
	localparam logic [39:0] ADDR_GN = "GNGGA";

	// one sentence verdict as the output channel carries it
	typedef struct packed {
		nsc_pkg::status_t st;
		logic             gga;
		logic [7:0]       csum;
		logic [7:0]       rsum;
		logic [7:0]       blen;
	} verdict_t;

	// directed stimulus row; a known verdict overrides the tracker's for that row
	typedef struct {
		string    text;
		bit       nul_first;
		bit       known;
		verdict_t v;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] status;
	logic       is_gga;
	logic [7:0] computed_sum;
	logic [7:0] received_sum;
	logic [7:0] body_length;

	nmea_sentence_checker #(
		.MAX_SENTENCE(MAX_BODY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.is_gga      (is_gga),
		.computed_sum(computed_sum),
		.received_sum(received_sum),
		.body_length (body_length)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// sentence tracker state, mirrors what the block must hold
	nsc_pkg::phase_t trk_phase;
	logic [7:0]      trk_xor;
	logic [3:0]      trk_hi;
	logic [7:0]      trk_len;
	bit              trk_gp;
	bit              trk_gn;
	bit              trk_hexbad;

	verdict_t   expected_q[$];
	verdict_t   want;
	dir_row_t   dir_rows[$];
	bit         use_known;
	verdict_t   known_val;
	bit         steady;        // no idling on either side while set
	int         live_chars;
	int         mismatches;
	int         cycles;

	// {bad, value} of one hex digit, either case
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
		if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 10)};
		if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 10)};
		return 5'b1_0000;
	endfunction

	function automatic verdict_t close_sentence(input nsc_pkg::status_t st,
			input logic [7:0] rs);
		verdict_t r;
		r.st   = st;
		r.gga  = (trk_len >= nsc_pkg::ADDR_LEN) && (trk_gp || trk_gn);
		r.csum = trk_xor;
		r.rsum = rs;
		r.blen = trk_len;
		trk_phase = nsc_pkg::PH_IDLE;
		return r;
	endfunction

	// steps the tracker by one character; returns 1 when a sentence closes
	function automatic bit track_char(input logic [7:0] c, output verdict_t r);
		bit         eol;
		logic [4:0] hv;
		logic [7:0] rs;
		eol = (c == nsc_pkg::CH_CR) || (c == nsc_pkg::CH_LF);
		hv  = hex_nibble(c);
		r   = '0;
		if (c == nsc_pkg::CH_DOLLAR) begin
			// start or restart: partial sentence vanishes without a verdict
			trk_phase  = nsc_pkg::PH_BODY;
			trk_xor    = 8'd0;
			trk_hi     = 4'd0;
			trk_len    = 8'd0;
			trk_gp     = 1'b1;
			trk_gn     = 1'b1;
			trk_hexbad = 1'b0;
			return 1'b0;
		end
		case (trk_phase)
			nsc_pkg::PH_BODY: begin
				if (c == nsc_pkg::CH_STAR) begin
					trk_phase = nsc_pkg::PH_HEX1;
					return 1'b0;
				end
				if (eol) begin
					r = close_sentence(nsc_pkg::ST_MALFORMED, 8'd0);
					return 1'b1;
				end
				if (trk_len >= MAX_BODY) begin
					// overlong: silently dropped
					trk_phase = nsc_pkg::PH_IDLE;
					return 1'b0;
				end
				if (trk_len < nsc_pkg::ADDR_LEN) begin
					if (c != ADDR_GP[39 - 8 * trk_len -: 8]) trk_gp = 1'b0;
					if (c != ADDR_GN[39 - 8 * trk_len -: 8]) trk_gn = 1'b0;
				end
				trk_xor = trk_xor ^ c;
				trk_len = trk_len + 8'd1;
				return 1'b0;
			end
			nsc_pkg::PH_HEX1: begin
				if (eol) begin
					r = close_sentence(nsc_pkg::ST_MALFORMED, 8'd0);
					return 1'b1;
				end
				if (hv[4]) begin
					trk_hexbad = 1'b1;
					trk_hi     = 4'd0;
				end else begin
					trk_hi = hv[3:0];
				end
				trk_phase = nsc_pkg::PH_HEX2;
				return 1'b0;
			end
			nsc_pkg::PH_HEX2: begin
				if (eol || hv[4] || trk_hexbad) begin
					r = close_sentence(nsc_pkg::ST_MALFORMED, 8'd0);
					return 1'b1;
				end
				rs = {trk_hi, hv[3:0]};
				if (trk_len < nsc_pkg::MIN_BODY) r = close_sentence(nsc_pkg::ST_MALFORMED, rs);
				else if (rs == trk_xor) r = close_sentence(nsc_pkg::ST_OK, rs);
				else r = close_sentence(nsc_pkg::ST_MISMATCH, rs);
				return 1'b1;
			end
			default: begin
				trk_phase = nsc_pkg::PH_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	// one input transaction, with random idle cycles ahead of it unless steady is set
	task automatic push_char(input logic [7:0] c);
		verdict_t v;
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		rx_byte  <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (trk_phase != nsc_pkg::PH_IDLE || c == nsc_pkg::CH_DOLLAR) live_chars++;
		if (track_char(c, v)) expected_q = {expected_q, (use_known ? known_val : v)};
	endtask

	task automatic add_row(input string text, input bit nul_first);
		dir_row_t row;
		row.text      = text;
		row.nul_first = nul_first;
		row.known     = 1'b0;
		row.v         = '0;
		dir_rows      = {dir_rows, row};
	endtask

	task automatic add_known(input string text, input nsc_pkg::status_t st, input logic gga,
			input logic [7:0] cs, input logic [7:0] rs, input logic [7:0] len);
		dir_row_t row;
		row.text      = text;
		row.nul_first = 1'b0;
		row.known     = 1'b1;
		row.v.st      = st;
		row.v.gga     = gga;
		row.v.csum    = cs;
		row.v.rsum    = rs;
		row.v.blen    = len;
		dir_rows      = {dir_rows, row};
	endtask

	// any byte that does not steer the sentence framing
	function automatic logic [7:0] body_char();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == nsc_pkg::CH_DOLLAR || b == nsc_pkg::CH_STAR ||
			b == nsc_pkg::CH_CR || b == nsc_pkg::CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] b;
		logic [4:0] h;
		do begin
			b = 8'($urandom_range(0, 255));
			h = hex_nibble(b);
		end while (!h[4] || b == nsc_pkg::CH_DOLLAR || b == nsc_pkg::CH_CR ||
			b == nsc_pkg::CH_LF);
		return b;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] line_end();
		return $urandom_range(0, 1) ? nsc_pkg::CH_CR : nsc_pkg::CH_LF;
	endfunction

	// Mostly well-formed sentences with GGA-like addresses and random bodies;
	// the rest carries bad checksums, bad hex, line ends and truncations.
	task automatic random_sentence();
		logic [7:0]  plan[$];
		logic [39:0] addr;
		logic [7:0]  sum;
		logic [7:0]  rs;
		int          roll;
		int          alen;
		int          blen;
		int          k;
		int          bad_pos;
		roll = $urandom_range(0, 99);
		addr = (roll < 30) ? ADDR_GP : (roll < 55) ? ADDR_GN : ADDR_GP;
		if (roll >= 55 && roll < 70) addr[8 * $urandom_range(0, 4) +: 8] = body_char();
		alen = ($urandom_range(0, 99) < 80) ? nsc_pkg::ADDR_LEN :
			$urandom_range(0, nsc_pkg::ADDR_LEN - 1);
		blen = ($urandom_range(0, 49) == 0) ?
			$urandom_range(MAX_BODY - 8, MAX_BODY + 4) - alen : $urandom_range(0, 15);
		sum = 8'd0;
		plan = {plan, nsc_pkg::CH_DOLLAR};
		for (k = 0; k < alen + blen; k++) begin
			if (k < alen && roll < 70) plan = {plan, addr[39 - 8 * k -: 8]};
			else plan = {plan, body_char()};
			sum = sum ^ plan[plan.size() - 1];
		end
		roll = $urandom_range(0, 99);
		if (roll < 77) begin
			// good checksum, or a wrong one
			rs = (roll < 65) ? sum : sum ^ 8'($urandom_range(1, 255));
			plan = {plan, nsc_pkg::CH_STAR};
			plan = {plan, hex_char(rs[7:4])};
			plan = {plan, hex_char(rs[3:0])};
		end else if (roll < 82) begin
			bad_pos = $urandom_range(0, 1);
			plan = {plan, nsc_pkg::CH_STAR};
			plan = {plan, (bad_pos == 0 ? non_hex_char() : hex_char(sum[7:4]))};
			plan = {plan, (bad_pos == 1 ? non_hex_char() : hex_char(sum[3:0]))};
		end else if (roll < 86) begin
			plan = {plan, line_end()};
		end else if (roll < 90) begin
			plan = {plan, nsc_pkg::CH_STAR};
			if ($urandom_range(0, 1)) plan = {plan, hex_char(sum[7:4])};
			plan = {plan, line_end()};
		end
		// otherwise it stays open until a CR below closes it or the next dollar restarts it
		if ($urandom_range(0, 1)) begin
			plan = {plan, nsc_pkg::CH_CR};
			plan = {plan, nsc_pkg::CH_LF};
		end
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3)) plan = {plan, 8'($urandom_range(0, 255))};
		end
		foreach (plan[i]) push_char(plan[i]);
	endtask

	// result side: random stalls unless steady; compare each transaction with oldest verdict
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("unexpected result: st=%0d gga=%0d csum=%02h rsum=%02h len=%0d",
						status, is_gga, computed_sum, received_sum, body_length);
				mismatches++;
			end else begin
				want = expected_q.pop_front();
				if (status !== want.st || is_gga !== want.gga || computed_sum !== want.csum ||
						received_sum !== want.rsum || body_length !== want.blen) begin
					if (mismatches < REPORT_MAX) begin
						$write("mismatch: exp st=%0d gga=%0d csum=%02h rsum=%02h len=%0d | ",
							want.st, want.gga, want.csum, want.rsum, want.blen);
						$display("got st=%0d gga=%0d csum=%02h rsum=%02h len=%0d",
							status, is_gga, computed_sum, received_sum, body_length);
					end
					mismatches++;
				end
			end
		end
		out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_nmea_sentence_checker failed");
			$finish;
		end
	end

	initial begin
		string q128;
		int    i;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		rx_byte    = 8'd0;
		out_ready  = 1'b0;
		steady     = 1'b0;
		use_known  = 1'b0;
		known_val  = '0;
		live_chars = 0;
		mismatches = 0;
		cycles     = 0;
		trk_phase  = nsc_pkg::PH_IDLE;
		trk_xor    = 8'd0;
		trk_hi     = 4'd0;
		trk_len    = 8'd0;
		trk_gp     = 1'b1;
		trk_gn     = 1'b1;
		trk_hexbad = 1'b0;

		q128 = "";
		for (i = 0; i < MAX_BODY; i++) q128 = {q128, "Q"};

		// directed table
		add_row("A\377\015\012*", 1'b1);                          // noise while idle, NUL first
		add_known("$*00", nsc_pkg::ST_MALFORMED, 1'b0, 8'h00, 8'h00, 8'd0);  // empty body
		add_known("$ABCD\015", nsc_pkg::ST_MALFORMED, 1'b0, 8'h04, 8'h00, 8'd4);  // CR in body
		add_row("$ABCD\012", 1'b0);                                // LF in body
		add_known("$GPGGA,1*4B", nsc_pkg::ST_OK, 1'b1, 8'h4B, 8'h4B, 8'd7);
		add_row("$GNGGA,1*55", 1'b0);
		add_row("$GPGGA,1*4b", 1'b0);                              // lowercase hex
		add_row("$GPGGA,1*4C", 1'b0);                              // mismatch
		add_row("$GPGG$GNGGA,1*55", 1'b0);                         // restart mid-sentence
		add_known("$GPGGA*Zz", nsc_pkg::ST_MALFORMED, 1'b1, 8'h56, 8'h00, 8'd5);  // bad hex
		add_row("$GPGGA**1", 1'b0);                                // star in hex position
		add_row("$ABCDE*0\012", 1'b0);                             // line end in checksum
		add_row("$ABCDE*\015", 1'b0);
		add_known("$ABC*af", nsc_pkg::ST_MALFORMED, 1'b0, 8'h40, 8'hAF, 8'd3);   // too short
		add_row("$GPGGX*00", 1'b0);                                // not a GGA address
		add_row("$GPGG*7F", 1'b0);                                 // address cut short
		add_row("$\001\177\200\377*FF", 1'b0);                     // extreme body bytes
		add_known({"$", q128, "*00"}, nsc_pkg::ST_OK, 1'b0, 8'h00, 8'h00, 8'd128);  // longest
		add_row({"$", q128, "Q*00\015\012"}, 1'b0);                // one over: dropped

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r]) begin
			use_known = dir_rows[r].known;
			known_val = dir_rows[r].v;
			if (dir_rows[r].nul_first) push_char(8'h00);
			for (i = 0; i < dir_rows[r].text.len(); i++) push_char(dir_rows[r].text[i]);
		end
		use_known = 1'b0;

		// random part, with a stretch of back-to-back traffic in the middle
		live_chars = 0;
		while (live_chars < RANDOM_CHARS) begin
			steady = (live_chars >= 700 && live_chars < 1000);
			random_sentence();
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb_nmea_sentence_checker passed");
		else
			$display("tb_nmea_sentence_checker failed");
		$finish;
	end

endmodule
